// File: hdl/aesmix_pkg.sv
// Package for the configurable-mix AES-shaped encryptor.
// Types, register indexes, S-box and GF(2^8) helpers; no dependencies.
package aesmix_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_LOW     = 3'd0,
    REG_KEY_HIGH    = 3'd1,
    REG_MIX_LOW     = 3'd2,
    REG_MIX_HIGH    = 3'd3,
    REG_ROUND_COUNT = 3'd4,
    REG_PROJ_INDEX  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } in_item_t;

  typedef struct packed {
    logic [31:0] projection;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_item_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= p;
      p = xtime(p);
    end
    return acc;
  endfunction

  // SubBytes then ShiftRows: row i of column c takes row i of column c+i
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[8*(4*c+i) +: 8] = sbox(s[8*(4*((c+i)%4)+i) +: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] t, input logic [127:0] m);
    logic [127:0] s;
    logic [7:0]   acc;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        acc = 8'h00;
        for (int j = 0; j < 4; j++) begin
          acc ^= gf_mul(m[8*(4*i+j) +: 8], t[8*(4*c+j) +: 8]);
        end
        s[8*(4*c+i) +: 8] = acc;
      end
    end
    return s;
  endfunction

  function automatic logic [127:0] next_rk(input logic [127:0] k, input logic [7:0] rc);
    logic [127:0] n;
    logic [31:0]  w;
    w = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]),
         sbox(k[111:104]) ^ rc};
    n[31:0]   = k[31:0]   ^ w;
    n[63:32]  = k[63:32]  ^ n[31:0];
    n[95:64]  = k[95:64]  ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    return n;
  endfunction

endpackage

// File: hdl/aesmix_key_sched.sv
// Key schedule: expands the key registers into all round keys, one
// round key per register stage. Depends on aesmix_pkg.
module aesmix_key_sched #(
  parameter int unsigned MaxRounds = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [127:0]               key_i,
  output logic [MaxRounds:0][127:0]  rk_o
);
  import aesmix_pkg::*;

  logic [MaxRounds:0][127:0] rk_q;
  logic [MaxRounds:0][7:0]   rc;

  always_comb begin
    rc[0] = 8'h01;
    for (int r = 1; r <= MaxRounds; r++) rc[r] = xtime(rc[r-1]);
  end

  // each round key is registered from the one before it; the first from key_i
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rk_q <= '0;
    end else begin
      rk_q[0] <= key_i;
      for (int r = 1; r <= MaxRounds; r++) rk_q[r] <= next_rk(rk_q[r-1], rc[r-1]);
    end
  end

  assign rk_o = rk_q;
endmodule

// File: hdl/aesmix_round.sv
// One pipelined cipher round: SubBytes/ShiftRows, optional mixing,
// AddRoundKey, with a bypass for rounds beyond the round count. Uses aesmix_pkg.
module aesmix_round (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [127:0] state_i,
  input  logic         active_i,
  input  logic         last_i,
  input  logic [127:0] mat_i,
  input  logic [127:0] rk_i,
  output logic         valid_o,
  output logic [127:0] state_o
);
  import aesmix_pkg::*;

  logic         valid_q;
  logic         act_q, last_q;
  logic [127:0] t_q, rk_q, mat_q, by_q;
  logic [127:0] mixed;

  // stage A: substitution
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= sub_shift(state_i);
    by_q   <= state_i;
    act_q  <= active_i;
    last_q <= last_i;
    rk_q   <= rk_i;
    mat_q  <= mat_i;
  end

  assign mixed = last_q ? t_q : mix(t_q, mat_q);

  // stage B: mixing and key add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    state_o <= act_q ? (mixed ^ rk_q) : by_q;
  end
endmodule

// File: hdl/aes_spn_configurable_mix_encrypt.sv
// Configurable-mix AES-128-shaped encryptor, unrolled round pipeline.
// Pipeline: key-add register, two register stages (A, B) per round, then
// the output register; one block accepted every cycle (busy stays low).
// Results cannot be stalled. Async active-low reset clears valids and
// config but sets the round count to 10. Round keys settle after a key write.
module aes_spn_configurable_mix_encrypt #(
  parameter int unsigned MAX_ROUNDS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  aesmix_pkg::in_item_t        in_i,
  output logic                        done_o,
  output aesmix_pkg::out_item_t       out_o,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [63:0]                 cfg_data_i
);
  import aesmix_pkg::*;

  localparam int unsigned RW = $clog2(MAX_ROUNDS + 1);

  logic [127:0] key_q, mat_q;
  logic [3:0]   rounds_q;
  logic [1:0]   proj_q;
  logic [RW-1:0] nr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      mat_q    <= '0;
      rounds_q <= 4'd10;
      proj_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_LOW:     key_q[63:0]   <= cfg_data_i;
        REG_KEY_HIGH:    key_q[127:64] <= cfg_data_i;
        REG_MIX_LOW:     mat_q[63:0]   <= cfg_data_i;
        REG_MIX_HIGH:    mat_q[127:64] <= cfg_data_i;
        REG_ROUND_COUNT: rounds_q      <= cfg_data_i[3:0];
        REG_PROJ_INDEX:  proj_q        <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rounds_q == 4'd0) nr = RW'(1);
    else if (32'(rounds_q) > MAX_ROUNDS) nr = RW'(MAX_ROUNDS);
    else nr = RW'(rounds_q);
  end

  logic [MAX_ROUNDS:0][127:0] rk;

  aesmix_key_sched #(.MaxRounds(MAX_ROUNDS)) u_ks (
    .clk_i, .rst_ni, .key_i(key_q), .rk_o(rk)
  );

  logic [MAX_ROUNDS:0]        v;
  logic [MAX_ROUNDS:0][127:0] st;
  logic                       v0_q;
  logic [127:0]               s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= in_i ^ rk[0];
  end

  assign v[0]  = v0_q;
  assign st[0] = s0_q;

  for (genvar r = 1; r <= MAX_ROUNDS; r++) begin : g_rnd
    aesmix_round u_rnd (
      .clk_i, .rst_ni,
      .valid_i (v[r-1]),
      .state_i (st[r-1]),
      .active_i(RW'(r) <= nr),
      .last_i  (RW'(r) == nr),
      .mat_i   (mat_q),
      .rk_i    (rk[r]),
      .valid_o (v[r]),
      .state_o (st[r])
    );
  end

  logic [127:0] c;
  logic [31:0]  pj;
  assign c = st[MAX_ROUNDS];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pj[8*i +: 8] = c[8*(4*((proj_q - 2'(i)) & 2'd3) + i) +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= v[MAX_ROUNDS];
    end
  end

  always_ff @(posedge clk_i) begin
    out_o <= '{projection: pj, cipher_high: c[127:64], cipher_low: c[63:0]};
  end

  assign busy = 1'b0;

  assert property (@(posedge clk_i) disable iff (!rst_ni) start |=> v[0])
    else $error("accepted block lost at key add");
  assert property (@(posedge clk_i) disable iff (!rst_ni) v[0] |-> ##2 v[1])
    else $error("first round dropped a block");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !v[MAX_ROUNDS] |=> !done_o)
    else $error("result strobe without a block");
endmodule
